// ----- sv/rtcld_pkg.sv -----
// Shared types, constants and helper functions of the RTC BCD local time decode unit.
`default_nettype none

package rtcld_pkg;

   localparam logic [6:0]         OffsetMax   = 7'd104;
   localparam logic signed [12:0] OffsetBias  = 13'sd48;
   localparam logic signed [12:0] QuarterMins = 13'sd15;
   localparam logic signed [12:0] HourMins    = 13'sd60;
   localparam logic signed [12:0] DayMins     = 13'sd1440;
   localparam logic signed [12:0] TwoDayMins  = 13'sd2880;
   localparam logic [21:0]        RecipSixty  = 22'd1093;
   localparam logic [11:0]        BaseYear    = 12'd2000;
   localparam logic [7:0]         LastYear    = 8'd99;

   // Decoded register snapshot.
   typedef struct packed {
      logic [6:0] minute;
      logic [5:0] hour;
      logic [7:0] yy;
      logic [4:0] month;
      logic [5:0] day;
   } dec_type;

   // Minute-of-day sum with offset, plus the checked date.
   typedef struct packed {
      logic signed [12:0] total;
      logic [6:0]         yy;
      logic [3:0]         month;
      logic [4:0]         day;
      logic               leap;
      logic               dvalid;
   } sum_type;

   // Wrapped minutes of the day and the shifted date.
   typedef struct packed {
      logic [10:0] wrapped;
      logic [6:0]  yy;
      logic [3:0]  month;
      logic [4:0]  day;
      logic        valid;
   } shift_type;

   typedef struct packed {
      logic [10:0] wrapped;
      logic [4:0]  hour;
      logic [6:0]  yy;
      logic [3:0]  month;
      logic [4:0]  day;
      logic        valid;
   } hour_type;

   typedef struct packed {
      logic [4:0]  local_hour;
      logic [5:0]  local_minute;
      logic [4:0]  display_hour;
      logic        is_pm;
      logic [11:0] local_year;
      logic [3:0]  local_month;
      logic [4:0]  local_day;
      logic        date_valid;
   } rsp_type;

   // Two BCD digits to binary, without a digit check (at most 165).
   function automatic logic [7:0] bcd_value(input logic [7:0] b);
      logic [7:0] hi;
      logic [7:0] lo;
      hi = {4'd0, b[7:4]};
      lo = {4'd0, b[3:0]};
      return (hi << 3) + (hi << 1) + lo;
   endfunction

   function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
      logic [4:0] d;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
         4'd2:                                        d = leap ? 5'd29 : 5'd28;
         default:                                     d = 5'd0;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

// ----- sv/rtcld_decode.sv -----
// First pipeline stage: masks and decodes the BCD register bytes.
`default_nettype none

module rtcld_decode import rtcld_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   output logic            in_ready,
   input  wire logic [7:0] raw_minute,
   input  wire logic [7:0] raw_hour,
   input  wire logic [7:0] raw_date,
   input  wire logic [7:0] raw_month,
   input  wire logic [7:0] raw_year,
   output logic            out_valid,
   input  wire logic       out_ready,
   output dec_type         out_data
);

   logic    valid_ff;
   logic    valid_in;
   dec_type data_ff;
   dec_type data_in;
   logic [7:0] min_bin;
   logic [7:0] h12_bin;
   logic [7:0] h24_bin;
   logic [7:0] day_bin;
   logic [7:0] mon_bin;
   logic [5:0] h12;

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      min_bin = bcd_value({1'b0, raw_minute[6:0]});
      h12_bin = bcd_value({3'd0, raw_hour[4:0]});
      h24_bin = bcd_value({2'd0, raw_hour[5:0]});
      day_bin = bcd_value({2'd0, raw_date[5:0]});
      mon_bin = bcd_value({3'd0, raw_month[4:0]});

      // Twelve o'clock in 12-hour form counts as zero before PM adds twelve.
      h12 = (h12_bin == 8'd12) ? 6'd0 : h12_bin[5:0];
      if (raw_hour[5]) begin
         h12 = h12 + 6'd12;
      end

      data_in.minute = min_bin[6:0];
      data_in.hour   = raw_hour[6] ? h12 : h24_bin[5:0];
      data_in.yy     = bcd_value(raw_year);
      data_in.month  = mon_bin[4:0];
      data_in.day    = day_bin[5:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/rtcld_sum.sv -----
// Second pipeline stage: minute-of-day sum with the UTC offset and the input date check.
`default_nettype none

module rtcld_sum import rtcld_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [6:0] offset_quarters,
   input  wire logic       in_valid,
   output logic            in_ready,
   input  wire dec_type    in_data,
   output logic            out_valid,
   input  wire logic       out_ready,
   output sum_type         out_data
);

   logic    valid_ff;
   logic    valid_in;
   sum_type data_ff;
   sum_type data_in;
   logic [6:0]         off;
   logic signed [12:0] quarters;
   logic signed [12:0] mod_day;
   logic               leap;
   logic [4:0]         mdays;

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      off      = (offset_quarters > OffsetMax) ? OffsetMax : offset_quarters;
      quarters = $signed({6'd0, off}) - OffsetBias;
      mod_day  = $signed({7'd0, in_data.hour}) * HourMins + $signed({6'd0, in_data.minute});

      // Within 2000..2099 a year is leap exactly when it divides by four.
      leap  = (in_data.yy[1:0] == 2'd0);
      mdays = month_days(in_data.month[3:0], leap);

      data_in.total  = mod_day + quarters * QuarterMins;
      data_in.yy     = in_data.yy[6:0];
      data_in.month  = in_data.month[3:0];
      data_in.day    = in_data.day[4:0];
      data_in.leap   = leap;
      data_in.dvalid = (in_data.yy <= LastYear) && (in_data.month != 5'd0)
                    && (in_data.month <= 5'd12) && (in_data.day != 6'd0)
                    && (in_data.day <= {1'b0, mdays});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/rtcld_shift.sv -----
// Third pipeline stage: wraps the minutes of the day and moves the date by one day.
`default_nettype none

module rtcld_shift import rtcld_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire sum_type in_data,
   output logic         out_valid,
   input  wire logic    out_ready,
   output shift_type    out_data
);

   logic      valid_ff;
   logic      valid_in;
   shift_type data_ff;
   shift_type data_in;
   logic               neg;
   logic               ge_day;
   logic               ge_two;
   logic signed [12:0] wrapped;
   logic [4:0]         mdays;
   logic [4:0]         mdays_prev;
   logic [3:0]         month_prev;
   logic [6:0]         yy;
   logic [3:0]         month;
   logic [4:0]         day;
   logic               valid;

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      neg    = in_data.total[12];
      ge_day = !neg && (in_data.total >= DayMins);
      ge_two = !neg && (in_data.total >= TwoDayMins);

      if (neg) begin
         wrapped = in_data.total + DayMins;
      end else if (ge_two) begin
         wrapped = in_data.total - TwoDayMins;
      end else if (ge_day) begin
         wrapped = in_data.total - DayMins;
      end else begin
         wrapped = in_data.total;
      end

      month_prev = in_data.month - 4'd1;
      mdays      = month_days(in_data.month, in_data.leap);
      mdays_prev = month_days(month_prev, in_data.leap);

      yy    = in_data.yy;
      month = in_data.month;
      day   = in_data.day;
      valid = in_data.dvalid;

      // The date moves at most one day, even past two days of minutes.
      if (ge_day) begin
         if (in_data.day < mdays) begin
            day = in_data.day + 5'd1;
         end else begin
            day = 5'd1;
            if (in_data.month < 4'd12) begin
               month = in_data.month + 4'd1;
            end else begin
               month = 4'd1;
               yy    = in_data.yy + 7'd1;
               if (in_data.yy == LastYear[6:0]) begin
                  valid = 1'b0;
               end
            end
         end
      end else if (neg) begin
         if (in_data.day > 5'd1) begin
            day = in_data.day - 5'd1;
         end else if (in_data.month > 4'd1) begin
            month = month_prev;
            day   = mdays_prev;
         end else begin
            month = 4'd12;
            day   = 5'd31;
            yy    = in_data.yy - 7'd1;
            if (in_data.yy == 7'd0) begin
               valid = 1'b0;
            end
         end
      end

      data_in.wrapped = wrapped[10:0];
      data_in.yy      = valid ? yy : 7'd0;
      data_in.month   = valid ? month : 4'd0;
      data_in.day     = valid ? day : 5'd0;
      data_in.valid   = valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/rtcld_hour.sv -----
// Fourth pipeline stage: hour of day from the wrapped minutes by a reciprocal multiply.
`default_nettype none

module rtcld_hour import rtcld_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      in_valid,
   output logic           in_ready,
   input  wire shift_type in_data,
   output logic           out_valid,
   input  wire logic      out_ready,
   output hour_type       out_data
);

   logic     valid_ff;
   logic     valid_in;
   hour_type data_ff;
   hour_type data_in;
   logic [21:0] prod;

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      // For minutes below 1440, (x * 1093) >> 16 equals x / 60 exactly.
      prod            = {11'd0, in_data.wrapped} * RecipSixty;
      data_in.wrapped = in_data.wrapped;
      data_in.hour    = prod[20:16];
      data_in.yy      = in_data.yy;
      data_in.month   = in_data.month;
      data_in.day     = in_data.day;
      data_in.valid   = in_data.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/rtcld_format.sv -----
// Last pipeline stage: minute remainder, display hour, PM flag and the result register.
`default_nettype none

module rtcld_format import rtcld_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     twelve_hour,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire hour_type in_data,
   output logic          out_valid,
   input  wire logic     out_ready,
   output rsp_type       out_data
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;
   rsp_type data_in;
   logic [10:0] minute;
   logic        pm;
   logic [4:0]  half;

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      minute = in_data.wrapped - {6'd0, in_data.hour} * 11'd60;
      pm     = (in_data.hour >= 5'd12);
      half   = pm ? in_data.hour - 5'd12 : in_data.hour;

      data_in.local_hour   = in_data.hour;
      data_in.local_minute = minute[5:0];
      if (twelve_hour) begin
         data_in.display_hour = (half == 5'd0) ? 5'd12 : half;
      end else begin
         data_in.display_hour = in_data.hour;
      end
      data_in.is_pm       = pm;
      data_in.local_year  = in_data.valid ? BaseYear + {5'd0, in_data.yy} : 12'd0;
      data_in.local_month = in_data.month;
      data_in.local_day   = in_data.day;
      data_in.date_valid  = in_data.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/rtc_bcd_local_time_decode_unit.sv -----
// Top level of the RTC BCD local time decode unit: registers and five-stage pipeline.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  req_tdata: five raw RTC register bytes
//   rsp      out        rsp_tvalid/rsp_tready  rsp_tdata: local time and date, rsp_tuser: valid
//   csr      in         csr_we                 csr_addr, csr_wdata
//
// One snapshot enters per cycle while req_tready is high; its result passes through
// the stages decode, offset sum, wrap and day shift, hour and format, each stage one register.
// Reset clears the stage valid bits and loads the offset register with 48 and
// 24-hour mode. A stall on rsp holds each full stage; a stage with a bubble still
// takes a transfer, so req_tready drops only when all five stages are full.
`default_nettype none

module rtc_bcd_local_time_decode_unit import rtcld_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // raw_minute[7:0], raw_hour[15:8], raw_date[23:16], raw_month[31:24], raw_year[39:32]
   input  wire logic [39:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // local_hour[4:0], local_minute[10:5], display_hour[15:11], is_pm[16],
   // local_year[28:17], local_month[32:29], local_day[37:33], zero[39:38]
   output logic [39:0]      rsp_tdata,
   // date_valid[0]
   output logic             rsp_tuser,
   input  wire logic        csr_we,
   input  wire logic        csr_addr,
   input  wire logic [6:0]  csr_wdata
);

   localparam logic CsrOffset = 1'b0;
   localparam logic CsrTwelve = 1'b1;
   localparam logic [6:0] OffsetReset = 7'd48;

   logic [6:0] offset_ff;
   logic [6:0] offset_in;
   logic       twelve_ff;
   logic       twelve_in;

   logic      s1_valid, s1_ready;
   logic      s2_valid, s2_ready;
   logic      s3_valid, s3_ready;
   logic      s4_valid, s4_ready;
   dec_type   s1_data;
   sum_type   s2_data;
   shift_type s3_data;
   hour_type  s4_data;
   rsp_type   rsp_data;

   always_comb begin
      offset_in = offset_ff;
      twelve_in = twelve_ff;
      if (csr_we) begin
         case (csr_addr)
            CsrOffset: offset_in = csr_wdata;
            CsrTwelve: twelve_in = csr_wdata[0];
            default:   offset_in = offset_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= OffsetReset;
         twelve_ff <= 1'b0;
      end else begin
         offset_ff <= offset_in;
         twelve_ff <= twelve_in;
      end
   end

   rtcld_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .raw_minute (req_tdata[7:0]),
      .raw_hour   (req_tdata[15:8]),
      .raw_date   (req_tdata[23:16]),
      .raw_month  (req_tdata[31:24]),
      .raw_year   (req_tdata[39:32]),
      .out_valid  (s1_valid),
      .out_ready  (s1_ready),
      .out_data   (s1_data)
   );

   rtcld_sum u_sum (
      .clock           (clock),
      .reset           (reset),
      .offset_quarters (offset_ff),
      .in_valid        (s1_valid),
      .in_ready        (s1_ready),
      .in_data         (s1_data),
      .out_valid       (s2_valid),
      .out_ready       (s2_ready),
      .out_data        (s2_data)
   );

   rtcld_shift u_shift (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_data   (s2_data),
      .out_valid (s3_valid),
      .out_ready (s3_ready),
      .out_data  (s3_data)
   );

   rtcld_hour u_hour (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid),
      .in_ready  (s3_ready),
      .in_data   (s3_data),
      .out_valid (s4_valid),
      .out_ready (s4_ready),
      .out_data  (s4_data)
   );

   rtcld_format u_format (
      .clock       (clock),
      .reset       (reset),
      .twelve_hour (twelve_ff),
      .in_valid    (s4_valid),
      .in_ready    (s4_ready),
      .in_data     (s4_data),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_data    (rsp_data)
   );

   assign rsp_tdata = {2'b00, rsp_data.local_day, rsp_data.local_month, rsp_data.local_year,
                       rsp_data.is_pm, rsp_data.display_hour, rsp_data.local_minute,
                       rsp_data.local_hour};
   assign rsp_tuser = rsp_data.date_valid;

   // An invalid date must come out with all date fields cleared.
   a_invalid_date_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_data.date_valid) |->
         (rsp_data.local_year == 12'd0 && rsp_data.local_month == 4'd0
          && rsp_data.local_day == 5'd0))
      else $error("invalid date with nonzero date fields");

   // A valid date lies in range after the shift.
   a_valid_date_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_data.date_valid) |->
         (rsp_data.local_year >= 12'd2000 && rsp_data.local_year <= 12'd2099
          && rsp_data.local_month != 4'd0 && rsp_data.local_month <= 4'd12
          && rsp_data.local_day != 5'd0))
      else $error("valid date out of range");

   // The wrap and the reciprocal divide keep the time within one day.
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_data.local_hour <= 5'd23 && rsp_data.local_minute <= 6'd59
                      && rsp_data.is_pm == (rsp_data.local_hour >= 5'd12)))
      else $error("local time out of range");

   // A full pipeline under a stall must refuse new transfers.
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready && s1_valid && s2_valid && s3_valid && s4_valid)
         |-> !req_tready)
      else $error("transfer accepted into a full stalled pipeline");

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench of the RTC BCD local time decode unit.
`timescale 1ns / 1ps

module testbench import rtcld_pkg::*;;

   localparam logic RegUtcOffset  = 1'b0;
   localparam logic RegTwelveHour = 1'b1;

   localparam int MinutesPerDay  = 1440;
   localparam int OffsetCeiling  = 104;
   localparam int OffsetZero     = 48;
   localparam int WatchdogLimit  = 1000;

   typedef enum int {ReadyAlways, ReadyRandom, ReadyPeriodic} ready_mode_type;

   typedef struct {
      logic [7:0] minute;
      logic [7:0] hour;
      logic [7:0] date;
      logic [7:0] month;
      logic [7:0] year;
      logic [6:0] offset;
      logic       twelve;
      bit         typed;
      rsp_type    want;
   } snapshot_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we;
   logic        csr_addr;
   logic [6:0]  csr_wdata;

   logic [6:0]       offset_setting;
   logic             hour12_setting;
   rsp_type          pending_local_times[$];
   snapshot_row_type directed_rows[$];
   int               mismatch_count = 0;
   int               burst_left;
   int               idle_cycles;
   ready_mode_type   ready_mode = ReadyAlways;
   int               ready_mode_left = 0;
   rsp_type          observed;
   rsp_type          predicted;

   always #6 clock = ~clock;

   rtc_bcd_local_time_decode_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   function automatic int bcd_pair(input logic [7:0] b);
      return int'(b[7:4]) * 10 + int'(b[3:0]);
   endfunction

   function automatic logic [7:0] to_bcd(input int v);
      return {4'(v / 10), 4'(v % 10)};
   endfunction

   function automatic int days_in_month(input int year, input int month);
      bit leap_year;
      leap_year = ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
      case (month)
         2:             return leap_year ? 29 : 28;
         4, 6, 9, 11:   return 30;
         1, 3, 5, 7, 8, 10, 12: return 31;
         default:       return 0;
      endcase
   endfunction

   function automatic bit date_in_range(input int year, input int month, input int day);
      int last;
      last = days_in_month(year, month);
      return year >= 2000 && year <= 2099 && last > 0 && day >= 1 && day <= last;
   endfunction

   function automatic rsp_type time_date(input int h, input int m, input int disp,
                                         input int pm, input int y, input int mo,
                                         input int d, input int v);
      rsp_type r;
      r.local_hour   = 5'(h);
      r.local_minute = 6'(m);
      r.display_hour = 5'(disp);
      r.is_pm        = 1'(pm);
      r.local_year   = 12'(y);
      r.local_month  = 4'(mo);
      r.local_day    = 5'(d);
      r.date_valid   = 1'(v);
      return r;
   endfunction

   // Local time and date for one register snapshot under the given settings.
   function automatic rsp_type decode_local_time(input logic [39:0] snap,
                                                 input logic [6:0] offset_q,
                                                 input logic twelve);
      int minute, hour, h12, year, month, day, offset, total, wrapped, hour24;
      logic [7:0] rhr;
      bit ok;
      rsp_type r;
      rhr    = snap[15:8];
      minute = bcd_pair(snap[7:0] & 8'h7F);
      if (rhr[6]) begin
         h12 = bcd_pair(rhr & 8'h1F);
         if (h12 == 12) h12 = 0;
         hour = rhr[5] ? h12 + 12 : h12;
      end else begin
         hour = bcd_pair(rhr & 8'h3F);
      end
      day    = bcd_pair(snap[23:16] & 8'h3F);
      month  = bcd_pair(snap[31:24] & 8'h1F);
      year   = 2000 + bcd_pair(snap[39:32]);
      offset = (int'(offset_q) > OffsetCeiling) ? OffsetCeiling : int'(offset_q);
      total   = hour * 60 + minute + (offset - OffsetZero) * 15;
      wrapped = ((total % MinutesPerDay) + MinutesPerDay) % MinutesPerDay;
      hour24  = wrapped / 60;
      r.local_hour   = 5'(hour24);
      r.local_minute = 6'(wrapped % 60);
      r.is_pm        = hour24 >= 12;
      if (twelve) r.display_hour = (hour24 % 12 == 0) ? 5'd12 : 5'(hour24 % 12);
      else r.display_hour = 5'(hour24);

      // The date moves by one day at most, however far the sum runs.
      ok = date_in_range(year, month, day);
      if (ok && total >= MinutesPerDay) begin
         if (day < days_in_month(year, month)) begin
            day++;
         end else begin
            day = 1;
            if (month < 12) month++;
            else begin
               month = 1;
               year++;
            end
         end
      end else if (ok && total < 0) begin
         if (day > 1) begin
            day--;
         end else begin
            if (month > 1) month--;
            else begin
               month = 12;
               year--;
            end
            day = days_in_month(year, month);
         end
      end
      ok = ok && date_in_range(year, month, day);
      r.date_valid  = ok;
      r.local_year  = ok ? 12'(year) : 12'd0;
      r.local_month = ok ? 4'(month) : 4'd0;
      r.local_day   = ok ? 5'(day) : 5'd0;
      return r;
   endfunction

   // Mostly plausible clock snapshots, with corrupted bytes and raw noise mixed in.
   function automatic logic [39:0] random_snapshot();
      int sel, yy, mo, dd, hh, mm, last, h12, pick;
      logic [63:0] wide;
      logic [7:0]  rmin, rhr, rdt, rmo, ryr;
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
         wide = {$urandom, $urandom};
         return wide[39:0];
      end
      pick = $urandom_range(0, 9);
      yy   = (pick == 0) ? 0 : (pick == 1) ? 99 : $urandom_range(0, 99);
      mo   = $urandom_range(1, 12);
      last = days_in_month(2000 + yy, mo);
      pick = $urandom_range(0, 9);
      dd   = (pick < 3) ? 1 : (pick < 6) ? last : $urandom_range(1, last);
      hh   = $urandom_range(0, 23);
      mm   = $urandom_range(0, 59);
      rmin = {1'($urandom), 7'(to_bcd(mm))};
      if ($urandom_range(0, 1)) begin
         h12 = hh % 12;
         if (h12 == 0) h12 = 12;
         rhr = {1'($urandom), 1'b1, 1'(hh >= 12), 5'(to_bcd(h12))};
      end else begin
         rhr = {1'($urandom), 1'b0, 6'(to_bcd(hh))};
      end
      rdt = {2'($urandom), 6'(to_bcd(dd))};
      rmo = {3'($urandom), 5'(to_bcd(mo))};
      ryr = to_bcd(yy);
      if (sel < 22) begin
         case ($urandom_range(0, 4))
            0: rmin = 8'($urandom);
            1: rhr  = 8'($urandom);
            2: rdt  = 8'($urandom);
            3: rmo  = 8'($urandom);
            default: ryr = 8'($urandom);
         endcase
      end
      return {ryr, rmo, rdt, rhr, rmin};
   endfunction

   task automatic add_row(input logic [7:0] minute, input logic [7:0] hour,
                          input logic [7:0] date, input logic [7:0] month,
                          input logic [7:0] year, input logic [6:0] offset,
                          input logic twelve, input bit typed = 1'b0,
                          input rsp_type want = '0);
      snapshot_row_type row;
      row.minute = minute;
      row.hour   = hour;
      row.date   = date;
      row.month  = month;
      row.year   = year;
      row.offset = offset;
      row.twelve = twelve;
      row.typed  = typed;
      row.want   = want;
      directed_rows.push_back(row);
   endtask

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("MISMATCH at %0t ns: %s", $time, what);
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
   endtask

   // Drops valid and waits until every outstanding result has come back.
   task automatic hold_until_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_local_times.size() != 0) @(posedge clock);
      burst_left = $urandom_range(1, 30);
   endtask

   task automatic write_register(input logic addr, input logic [6:0] value);
      hold_until_drained();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (addr == RegUtcOffset) offset_setting = value;
      else hour12_setting = value[0];
   endtask

   task automatic send_snapshot(input logic [39:0] snap, input rsp_type want);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= snap;
      do @(posedge clock); while (!req_tready);
      pending_local_times.push_back(want);
      burst_left--;
      if (burst_left <= 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(0, 12)) @(negedge clock);
         burst_left = $urandom_range(1, 30);
      end
   endtask

   // Receiver: switches between always ready, random stalls and a periodic pattern.
   always @(negedge clock) begin
      if (ready_mode_left == 0) begin
         ready_mode      = ready_mode_type'($urandom_range(0, 2));
         ready_mode_left = $urandom_range(20, 80);
      end
      ready_mode_left--;
      case (ready_mode)
         ReadyAlways: rsp_tready <= 1'b1;
         ReadyRandom: rsp_tready <= ($urandom_range(0, 3) != 0);
         default:     rsp_tready <= (ready_mode_left % 7) < 2;
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         observed.local_hour   = rsp_tdata[4:0];
         observed.local_minute = rsp_tdata[10:5];
         observed.display_hour = rsp_tdata[15:11];
         observed.is_pm        = rsp_tdata[16];
         observed.local_year   = rsp_tdata[28:17];
         observed.local_month  = rsp_tdata[32:29];
         observed.local_day    = rsp_tdata[37:33];
         observed.date_valid   = rsp_tuser;
         if (pending_local_times.size() == 0) begin
            report_mismatch("result transfer with no expectation waiting");
         end else begin
            predicted = pending_local_times.pop_front();
            check_field("local_hour", observed.local_hour, predicted.local_hour);
            check_field("local_minute", observed.local_minute, predicted.local_minute);
            check_field("display_hour", observed.display_hour, predicted.display_hour);
            check_field("is_pm", observed.is_pm, predicted.is_pm);
            check_field("local_year", observed.local_year, predicted.local_year);
            check_field("local_month", observed.local_month, predicted.local_month);
            check_field("local_day", observed.local_day, predicted.local_day);
            check_field("date_valid", observed.date_valid, predicted.date_valid);
         end
      end
   end

   initial begin
      idle_cycles = 0;
      while (idle_cycles < WatchdogLimit) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("rtc_bcd_local_time_decode_unit regression: fail");
      $finish;
   end

   initial begin
      logic [39:0]      snap;
      logic [6:0]       phase_offset;
      snapshot_row_type row;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      rsp_tready     = 1'b0;
      csr_we         = 1'b0;
      csr_addr       = RegUtcOffset;
      csr_wdata      = '0;
      offset_setting = 7'd48;
      hour12_setting = 1'b0;
      burst_left     = $urandom_range(1, 30);

      // Settings after reset: zero offset, 24-hour display.
      add_row(8'h30, 8'h12, 8'h15, 8'h06, 8'h24, 7'd48, 1'b0, 1'b1,
              time_date(12, 30, 12, 1, 2024, 6, 15, 1));
      add_row(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 7'd48, 1'b0, 1'b1,
              time_date(0, 0, 0, 0, 0, 0, 0, 0));
      add_row(8'h59, 8'h23, 8'h31, 8'h12, 8'h99, 7'd48, 1'b0, 1'b1,
              time_date(23, 59, 23, 1, 2099, 12, 31, 1));
      add_row(8'h00, 8'h00, 8'h01, 8'h01, 8'h00, 7'd48, 1'b0, 1'b1,
              time_date(0, 0, 0, 0, 2000, 1, 1, 1));
      // Twelve o'clock in 12-hour form, AM and PM, then 11 PM.
      add_row(8'h00, 8'h52, 8'h01, 8'h01, 8'h00, 7'd48, 1'b0, 1'b1,
              time_date(0, 0, 0, 0, 2000, 1, 1, 1));
      add_row(8'h15, 8'h72, 8'h01, 8'h01, 8'h00, 7'd48, 1'b0, 1'b1,
              time_date(12, 15, 12, 1, 2000, 1, 1, 1));
      add_row(8'h45, 8'h71, 8'h01, 8'h01, 8'h00, 7'd48, 1'b0, 1'b1,
              time_date(23, 45, 23, 1, 2000, 1, 1, 1));
      // February 29 outside a leap year.
      add_row(8'h00, 8'h10, 8'h29, 8'h02, 8'h23, 7'd48, 1'b0, 1'b1,
              time_date(10, 0, 10, 0, 0, 0, 0, 0));
      add_row(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 7'd48, 1'b0);
      add_row(8'h7A, 8'h00, 8'h10, 8'h03, 8'h24, 7'd48, 1'b0);
      // Non-BCD hour far past midnight still shifts the date by one day only.
      add_row(8'h59, 8'h3F, 8'h31, 8'h12, 8'h24, 7'd48, 1'b0);
      add_row(8'h00, 8'h08, 8'h01, 8'h13, 8'h24, 7'd48, 1'b0);
      add_row(8'h00, 8'h08, 8'h29, 8'h02, 8'h24, 7'd48, 1'b0);
      add_row(8'h00, 8'h08, 8'h29, 8'h02, 8'h00, 7'd48, 1'b0);
      add_row(8'h00, 8'h08, 8'h31, 8'h04, 8'h24, 7'd48, 1'b0);
      // Most negative offset: backward rollover, including out of the year range.
      add_row(8'h00, 8'h05, 8'h01, 8'h01, 8'h00, 7'd0, 1'b0);
      add_row(8'h00, 8'h03, 8'h01, 8'h03, 8'h24, 7'd0, 1'b0);
      add_row(8'h00, 8'h00, 8'h01, 8'h01, 8'h23, 7'd0, 1'b0);
      // Most positive offset with 12-hour display: forward rollover.
      add_row(8'h00, 8'h12, 8'h31, 8'h12, 8'h99, 7'd104, 1'b1);
      add_row(8'h00, 8'h10, 8'h28, 8'h02, 8'h23, 7'd104, 1'b1);
      add_row(8'h59, 8'h23, 8'h30, 8'h06, 8'h24, 7'd104, 1'b1);
      // Offset above range behaves as the top of the range.
      add_row(8'h00, 8'h20, 8'h31, 8'h12, 8'h24, 7'd127, 1'b1);
      add_row(8'h00, 8'h00, 8'h15, 8'h07, 8'h24, 7'd127, 1'b1);
      add_row(8'h45, 8'h23, 8'h28, 8'h02, 8'h24, 7'd49, 1'b0);
      add_row(8'h00, 8'h00, 8'h01, 8'h03, 8'h24, 7'd47, 1'b1);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.offset != offset_setting) write_register(RegUtcOffset, row.offset);
         if (row.twelve != hour12_setting) write_register(RegTwelveHour, {6'd0, row.twelve});
         snap = {row.year, row.month, row.date, row.hour, row.minute};
         send_snapshot(snap, row.typed ? row.want
                                       : decode_local_time(snap, offset_setting, hour12_setting));
      end

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0:       phase_offset = 7'd0;
            1:       phase_offset = 7'd104;
            2:       phase_offset = 7'd127;
            3:       phase_offset = 7'd48;
            4:       phase_offset = 7'($urandom_range(0, 104));
            5:       phase_offset = 7'($urandom_range(105, 127));
            6:       phase_offset = 7'($urandom_range(0, 127));
            default: phase_offset = 7'd1;
         endcase
         write_register(RegUtcOffset, phase_offset);
         write_register(RegTwelveHour, {6'($urandom), 1'(phase % 2)});
         for (int n = 0; n < 50; n++) begin
            if (phase == 3 && n == 25) hold_until_drained();
            snap = random_snapshot();
            send_snapshot(snap, decode_local_time(snap, offset_setting, hour12_setting));
         end
      end

      hold_until_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("rtc_bcd_local_time_decode_unit regression: pass");
      else
         $display("rtc_bcd_local_time_decode_unit regression: fail");
      $finish;
   end

endmodule

// ----- files.f -----
sv/rtcld_pkg.sv
sv/rtcld_decode.sv
sv/rtcld_sum.sv
sv/rtcld_shift.sv
sv/rtcld_hour.sv
sv/rtcld_format.sv
sv/rtc_bcd_local_time_decode_unit.sv
verif/testbench.sv
